### rtl/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition implies consequence in the same cycle.
`define ASSERT_SAME(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("assertion failed");

// Condition implies consequence in the next cycle.
`define ASSERT_NEXT(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/pfs_pkg.sv
// Types, codes and sizes for the periodic frame scheduler.
`timescale 1ns / 1ps
`default_nettype none

package pfs_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_TICK   = 2'd2,
    FUNC_NOP    = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_ZERO      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef struct packed {
    func_t       func;
    logic [28:0] frame_id;
    logic        id_extended;
    logic [3:0]  payload_length;
    logic [15:0] send_period;
    logic [31:0] now_ms;
    logic [1:0]  free_slots;
  } req_t;

  typedef struct packed {
    logic        kind;
    status_t     status;
    logic [28:0] due_id;
    logic        due_extended;
    logic [3:0]  due_length;
    logic [3:0]  slot_index;
    logic        final_item;
  } rsp_t;

  typedef struct packed {
    logic [28:0] id;
    logic        extended;
    logic [3:0]  length;
    logic [15:0] period;
    logic [31:0] last_time;
  } entry_t;

endpackage

`default_nettype wire

### rtl/periodic_frame_scheduler.sv
// Periodic frame scheduler: entry table, sequencer and one result register.
// Steps per request: add checks each entry, then appends, then gives its status; remove
// searches and shifts the later entries down; tick visits each entry, then ends the scan.
// Input is stalled meanwhile, so a new request is taken only once the previous one is
// done, and a stall on the result side holds the sequencer as well.
// Reset (rst, synchronous) clears count and sequencer; only entries below count are read.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module periodic_frame_scheduler (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output      logic          req_stall,
  input  wire pfs_pkg::req_t req,
  output      logic          rsp_valid,
  input  wire logic          rsp_stall,
  output      pfs_pkg::rsp_t rsp
);
  import pfs_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CHECK  = 5'b00010,
    S_SHIFT  = 5'b00100,
    S_APPEND = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t            state, state_next;
  logic [IDX_W-1:0]  idx, idx_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [1:0]        slots, slots_next;
  status_t           st, st_next;
  req_t              req_q;
  entry_t            mem [MAX_ENTRIES];
  entry_t            rd_q;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_data;
  logic              load_rsp;
  rsp_t              rsp_next;
  logic              emit_ok;
  logic              accept;
  logic [CNT_W-1:0]  idx_inc;
  logic              last;
  logic [31:0]       due_time;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign emit_ok   = !rsp_valid || !rsp_stall;
  assign idx_inc   = CNT_W'(idx) + CNT_W'(1);
  assign last      = (idx_inc == count);
  assign due_time  = rd_q.last_time + 32'(rd_q.period);

  // Sequence the table walk
  always_comb begin
    state_next = state;
    idx_next   = idx;
    count_next = count;
    slots_next = slots;
    st_next    = st;
    wr_en      = 1'b0;
    wr_addr    = idx;
    wr_data    = rd_q;
    load_rsp   = 1'b0;
    rsp_next   = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          idx_next   = '0;
          slots_next = req.free_slots;
          st_next    = ST_OK;
          unique case (req.func)
            FUNC_ADD: begin
              if (count >= CNT_W'(MAX_ENTRIES - 1)) begin
                st_next    = ST_FULL;
                state_next = S_DONE;
              end else if (req.send_period == '0) begin
                st_next    = ST_ZERO;
                state_next = S_DONE;
              end else if (count == '0) begin
                state_next = S_APPEND;
              end else begin
                state_next = S_CHECK;
              end
            end
            FUNC_REMOVE: begin
              if (count == '0) begin
                st_next    = ST_NOT_FOUND;
                state_next = S_DONE;
              end else begin
                state_next = S_CHECK;
              end
            end
            FUNC_TICK: begin
              state_next = (count == '0) ? S_DONE : S_CHECK;
            end
            FUNC_NOP: begin
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_CHECK: begin
        unique case (req_q.func)
          FUNC_ADD: begin
            if (rd_q.id == req_q.frame_id) begin
              st_next    = ST_DUPLICATE;
              state_next = S_DONE;
            end else if (last) begin
              state_next = S_APPEND;
            end else begin
              idx_next = IDX_W'(idx_inc);
            end
          end
          FUNC_REMOVE: begin
            if (rd_q.id == req_q.frame_id) begin
              if (last) begin
                count_next = count - CNT_W'(1);
                state_next = S_DONE;
              end else begin
                idx_next   = IDX_W'(idx_inc);
                state_next = S_SHIFT;
              end
            end else if (last) begin
              st_next    = ST_NOT_FOUND;
              state_next = S_DONE;
            end else begin
              idx_next = IDX_W'(idx_inc);
            end
          end
          FUNC_TICK, FUNC_NOP: begin
            if (req_q.now_ms > due_time) begin
              if (slots == '0) begin
                state_next = S_DONE;
              end else if (emit_ok) begin
                // Emit the due frame and restamp it
                load_rsp              = 1'b1;
                rsp_next.kind         = 1'b1;
                rsp_next.status       = ST_OK;
                rsp_next.due_id       = rd_q.id;
                rsp_next.due_extended = rd_q.extended;
                rsp_next.due_length   = rd_q.length;
                rsp_next.slot_index   = 4'(idx);
                rsp_next.final_item   = 1'b0;
                wr_en                 = 1'b1;
                wr_data.last_time     = req_q.now_ms;
                slots_next            = slots - 2'd1;
                if (last) begin
                  state_next = S_DONE;
                end else begin
                  idx_next = IDX_W'(idx_inc);
                end
              end
            end else if (last) begin
              state_next = S_DONE;
            end else begin
              idx_next = IDX_W'(idx_inc);
            end
          end
        endcase
      end
      S_SHIFT: begin
        // Move entry down one place to close the gap
        wr_en   = 1'b1;
        wr_addr = idx - IDX_W'(1);
        wr_data = rd_q;
        if (last) begin
          count_next = count - CNT_W'(1);
          state_next = S_DONE;
        end else begin
          idx_next = IDX_W'(idx_inc);
        end
      end
      S_APPEND: begin
        wr_en             = 1'b1;
        wr_addr           = IDX_W'(count);
        wr_data.id        = req_q.frame_id;
        wr_data.extended  = req_q.id_extended;
        wr_data.length    = req_q.payload_length;
        wr_data.period    = req_q.send_period;
        wr_data.last_time = req_q.now_ms;
        count_next        = count + CNT_W'(1);
        state_next        = S_DONE;
      end
      S_DONE: begin
        if (emit_ok) begin
          load_rsp            = 1'b1;
          rsp_next.status     = st;
          rsp_next.final_item = 1'b1;
          state_next          = S_IDLE;
        end
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      idx   <= '0;
      slots <= '0;
      st    <= ST_OK;
    end else begin
      state <= state_next;
      count <= count_next;
      idx   <= idx_next;
      slots <= slots_next;
      st    <= st_next;
    end
  end

  // Hold the accepted request beat
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
  end

  // Entry table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[idx_next];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp <= rsp_next;
    end
  end

  `ASSERT_SAME(a_count_bound, 1'b1, count <= CNT_W'(MAX_ENTRIES - 1))
  `ASSERT_SAME(a_shift_in_range, state == S_SHIFT, CNT_W'(idx) < count)
  `ASSERT_NEXT(a_append_grows, state == S_APPEND, count == $past(count) + CNT_W'(1))
  `ASSERT_SAME(a_frame_not_final, rsp_valid && rsp.kind, !rsp.final_item)
  `ASSERT_SAME(a_load_only_free, load_rsp, emit_ok)

endmodule

`default_nettype wire

### sim/tb_periodic_frame_scheduler.sv
// Self-checking testbench for the periodic frame scheduler.
`timescale 1ns / 1ps

module tb_periodic_frame_scheduler;
  import pfs_pkg::*;

  localparam int DRAIN_CYCLES = 2 * MAX_ENTRIES + 4;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  periodic_frame_scheduler dut (
    .clk       (clk),
    .rsp_stall (rsp_stall),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

  // Shadow copy of the frame table and the results it predicts
  entry_t      sched_tab [MAX_ENTRIES];
  int          sched_cnt;
  rsp_t        rsp_expect_q[$];
  int          err_cnt;
  bit          idle_on;
  int          stall_left;
  rsp_t        rsp_want;
  logic [28:0] id_pool [24];
  logic [31:0] clock_ms;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic int find_entry(input logic [28:0] id);
    for (int i = 0; i < sched_cnt; i++) begin
      if (sched_tab[i].id == id) return i;
    end
    return -1;
  endfunction

  // Apply one accepted beat to the shadow table and queue its results
  task automatic predict_req(input req_t r);
    rsp_t        res;
    rsp_t        frame;
    int          hit;
    int          budget;
    logic [31:0] due_at;
    res = '0;
    res.final_item = 1'b1;
    case (r.func)
      FUNC_ADD: begin
        hit = find_entry(r.frame_id);
        if (sched_cnt >= MAX_ENTRIES - 1) begin
          res.status = ST_FULL;
        end else if (r.send_period == 16'd0) begin
          res.status = ST_ZERO;
        end else if (hit >= 0) begin
          res.status = ST_DUPLICATE;
        end else begin
          sched_tab[sched_cnt] = '{id: r.frame_id, extended: r.id_extended,
                                   length: r.payload_length, period: r.send_period,
                                   last_time: r.now_ms};
          sched_cnt++;
        end
      end
      FUNC_REMOVE: begin
        hit = find_entry(r.frame_id);
        if (hit < 0) begin
          res.status = ST_NOT_FOUND;
        end else begin
          // close the gap, keep order
          for (int j = hit; j + 1 < sched_cnt; j++) sched_tab[j] = sched_tab[j + 1];
          sched_cnt--;
        end
      end
      FUNC_TICK: begin
        budget = int'(r.free_slots);
        for (int i = 0; i < sched_cnt; i++) begin
          due_at = sched_tab[i].last_time + {16'd0, sched_tab[i].period};
          if (r.now_ms > due_at) begin
            // stop at the first due frame with no mailbox left
            if (budget == 0) break;
            budget--;
            frame = '0;
            frame.kind         = 1'b1;
            frame.due_id       = sched_tab[i].id;
            frame.due_extended = sched_tab[i].extended;
            frame.due_length   = sched_tab[i].length;
            frame.slot_index   = 4'(i);
            rsp_expect_q.push_back(frame);
            sched_tab[i].last_time = r.now_ms;
          end
        end
      end
      default: ;
    endcase
    rsp_expect_q.push_back(res);
  endtask

  // Send one request beat; valid stays high unless an idle burst follows
  task automatic send_req(input req_t r);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (req_stall);
    predict_req(r);
  endtask

  function automatic req_t rand_req(input func_t f);
    req_t r;
    r.func           = f;
    r.frame_id       = 29'($urandom);
    r.id_extended    = 1'($urandom);
    r.payload_length = 4'($urandom_range(0, 15));
    r.send_period    = 16'($urandom);
    r.now_ms         = $urandom;
    r.free_slots     = 2'($urandom);
    return r;
  endfunction

  function automatic req_t add_req(input logic [28:0] id, input logic ext,
                                   input logic [3:0] len, input logic [15:0] period,
                                   input logic [31:0] now);
    req_t r;
    r = rand_req(FUNC_ADD);
    r.frame_id       = id;
    r.id_extended    = ext;
    r.payload_length = len;
    r.send_period    = period;
    r.now_ms         = now;
    return r;
  endfunction

  function automatic req_t tick_req(input logic [31:0] now, input logic [1:0] slots);
    req_t r;
    r = rand_req(FUNC_TICK);
    r.now_ms     = now;
    r.free_slots = slots;
    return r;
  endfunction

  function automatic req_t remove_req(input logic [28:0] id);
    req_t r;
    r = rand_req(FUNC_REMOVE);
    r.frame_id = id;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      err_cnt++;
    end
  endtask

  // Check each accepted result beat, then pick the next stall state
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (rsp_expect_q.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %p", $time, rsp);
        err_cnt++;
      end else begin
        rsp_want = rsp_expect_q.pop_front();
        check_field("kind", 32'(rsp_want.kind), 32'(rsp.kind));
        check_field("status", 32'(rsp_want.status), 32'(rsp.status));
        check_field("due_id", 32'(rsp_want.due_id), 32'(rsp.due_id));
        check_field("due_extended", 32'(rsp_want.due_extended), 32'(rsp.due_extended));
        check_field("due_length", 32'(rsp_want.due_length), 32'(rsp.due_length));
        check_field("slot_index", 32'(rsp_want.slot_index), 32'(rsp.slot_index));
        check_field("final_item", 32'(rsp_want.final_item), 32'(rsp.final_item));
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      rsp_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 7);
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  // Status codes and their check order, no operation
  task automatic test_add_rules();
    req_t r;
    send_req(add_req(29'h1FFF_FFFF, 1'b1, 4'd8, 16'hFFFF, 32'hFFFF_FF00));
    send_req(add_req(29'h1FFF_FFFF, 1'b0, 4'd0, 16'd1, 32'hFFFF_FF00));
    send_req(add_req(29'h1FFF_FFFF, 1'b0, 4'd3, 16'd0, 32'hFFFF_FF00));
    send_req(remove_req(29'h123));
    r = rand_req(FUNC_NOP);
    send_req(r);
    send_req(add_req(29'h0, 1'b0, 4'd15, 16'd1, 32'hFFFF_FF00));
  endtask

  // Fill the table, then hit the full check ahead of zero period and duplicate
  task automatic test_full_table();
    for (int k = 0; k < MAX_ENTRIES - 3; k++) begin
      send_req(add_req(29'h100 + 29'(k), 1'(k), 4'(k), 16'(16 + 8 * k), 32'hFFFF_FF00));
    end
    send_req(add_req(29'h0ABC_DEF0, 1'b1, 4'd2, 16'd0, 32'hFFFF_FF10));
    send_req(add_req(29'h0, 1'b0, 4'd2, 16'd5, 32'hFFFF_FF10));
  endtask

  // Slot budget, early stop, wrapped due time
  task automatic test_tick_scan();
    send_req(tick_req(32'hFFFF_FF80, 2'd0));
    send_req(tick_req(32'hFFFF_FF80, 2'd3));
    send_req(tick_req(32'h0000_FF00, 2'd3));
  endtask

  // Remove from the middle, then scan to see the shifted positions
  task automatic test_remove_order();
    send_req(remove_req(29'h105));
    send_req(tick_req(32'h8000_0000, 2'd3));
  endtask

  // Mostly well-formed traffic on a small identifier pool with advancing time
  task automatic test_random_traffic(input int n_items, input int quiet_from);
    req_t r;
    int   sel;
    for (int k = 0; k < 24; k++) begin
      id_pool[k] = (k < 12) ? 29'($urandom_range(0, 2047)) : 29'($urandom);
    end
    clock_ms = $urandom;
    for (int n = 0; n < n_items; n++) begin
      if (n == quiet_from) idle_on = 1'b0;
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        r = rand_req(FUNC_ADD);
        if ($urandom_range(0, 4) != 0) r.frame_id = id_pool[$urandom_range(0, 23)];
        sel = $urandom_range(0, 99);
        if (sel < 5) r.send_period = 16'd0;
        else if (sel < 75) r.send_period = 16'($urandom_range(1, 40));
        r.now_ms = clock_ms;
      end else if (sel < 55) begin
        r = rand_req(FUNC_REMOVE);
        if ($urandom_range(0, 6) != 0) r.frame_id = id_pool[$urandom_range(0, 23)];
      end else if (sel < 95) begin
        if ($urandom_range(0, 32) == 0) clock_ms += $urandom;
        else clock_ms += 32'($urandom_range(0, 30));
        r = tick_req(clock_ms, 2'($urandom));
      end else begin
        r = rand_req(FUNC_NOP);
      end
      send_req(r);
    end
  endtask

  initial begin
    rst        <= 1'b1;
    req_valid  <= 1'b0;
    req        <= '0;
    sched_cnt  = 0;
    idle_on    = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_add_rules();
    test_full_table();
    test_tick_scan();
    test_remove_order();
    test_random_traffic(420, 340);

    // drain
    req_valid <= 1'b0;
    while (rsp_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
